// File: rtl/hmr_pkg.sv
package hmr_pkg;

  // Fixed payload widths of the two channels
  localparam int HEIGHT_IN_W = 16;
  localparam int AREA_W      = 26;

  // Largest area that fits the result field; larger products saturate here
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_bar;     // store the transferred bar or flag overflow
    logic start_left;   // begin left-boundary pass at bar 0
    logic push_left;    // record left bound, push bar, advance
    logic start_right;  // begin right pass at the last bar, clear best area
    logic push_right;   // compute area, push bar, step back
    logic pop;          // drop the stack top
    logic emit;         // load result register, start a new histogram
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pop_ok;     // stack not empty and current bar <= top height
    logic at_end_up;  // index is the last stored bar
    logic at_zero;    // index is bar 0
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// File: rtl/hmr_bar_if.sv
interface hmr_bar_if;
  logic        valid;
  logic        ready;
  logic [15:0] bar_height;
  logic        last_bar;

  modport source (output valid, output bar_height, output last_bar, input ready);
  modport sink (input valid, input bar_height, input last_bar, output ready);
endinterface

// File: rtl/hmr_area_if.sv
interface hmr_area_if;
  logic        valid;
  logic        ready;
  logic [25:0] max_area;
  logic        overflowed;

  modport source (output valid, output max_area, output overflowed, input ready);
  modport sink (input valid, input max_area, input overflowed, output ready);
endinterface

// File: rtl/hmr_ram.sv
module hmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/hmr_ctrl.sv
module hmr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  input  hmr_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output hmr_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L_WAIT,
    ST_L_STEP,
    ST_R_WAIT,
    ST_R_STEP,
    ST_R_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_bar = 1'b1;
          if (in_last_i) begin
            cmd_o.start_left = 1'b1;
            state_d          = ST_L_WAIT;
          end
        end
      end
      // height read of the current bar settles
      ST_L_WAIT: state_d = ST_L_STEP;
      ST_L_STEP: begin
        if (sts_i.pop_ok) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.push_left = 1'b1;
          if (sts_i.at_end_up) begin
            cmd_o.start_right = 1'b1;
            state_d           = ST_R_WAIT;
          end else begin
            state_d = ST_L_WAIT;
          end
        end
      end
      ST_R_WAIT: state_d = ST_R_STEP;
      ST_R_STEP: begin
        if (sts_i.pop_ok) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.push_right = 1'b1;
          state_d = sts_i.at_zero ? ST_R_DRAIN : ST_R_WAIT;
        end
      end
      // last product folds into the best area
      ST_R_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/hmr_dp.sv
module hmr_dp #(
  parameter int MAX_BARS    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hmr_pkg::cmd_t                  cmd_i,
  output hmr_pkg::sts_t                  sts_o,
  input  logic [hmr_pkg::HEIGHT_IN_W-1:0] bar_height_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [hmr_pkg::AREA_W-1:0]     max_area_o,
  output logic                           overflowed_o
);

  localparam int HW = (HEIGHT_BITS < hmr_pkg::HEIGHT_IN_W) ? HEIGHT_BITS
                                                           : hmr_pkg::HEIGHT_IN_W;
  localparam int IW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int CW = $clog2(MAX_BARS + 1);
  localparam int SW = HW + IW;
  localparam int PW = (CW + HW > hmr_pkg::AREA_W) ? CW + HW : hmr_pkg::AREA_W;

  logic [CW-1:0]             count_q;
  logic                      ovf_q;
  logic [IW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             depth_q, depth_d;
  logic [HW-1:0]             top_h_q;
  logic [IW-1:0]             top_idx_q;
  logic [HW-1:0]             h_rd;
  logic [CW-1:0]             left_rd;
  logic [SW-1:0]             stack_rd;
  logic                      count_full;
  logic                      push;
  logic                      stack_we;
  logic [CW-1:0]             left_wr;
  logic [CW-1:0]             right_bound;
  logic [CW-1:0]             span;
  logic [PW-1:0]             prod_d, prod_q;
  logic                      prod_vld_q;
  logic [hmr_pkg::AREA_W-1:0] area_sat;
  logic [hmr_pkg::AREA_W-1:0] best_q;

  assign count_full = (count_q == CW'(MAX_BARS));
  assign push       = cmd_i.push_left | cmd_i.push_right;
  assign stack_we   = push && (depth_q != '0);

  // Bar index and stack depth
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start_left) begin
      idx_d = '0;
    end else if (cmd_i.start_right) begin
      idx_d = IW'(count_q - CW'(1));
    end else if (cmd_i.push_left) begin
      idx_d = idx_q + IW'(1);
    end else if (cmd_i.push_right) begin
      idx_d = idx_q - IW'(1);
    end
  end

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.start_left || cmd_i.start_right) begin
      depth_d = '0;
    end else if (cmd_i.pop) begin
      depth_d = depth_q - CW'(1);
    end else if (push) begin
      depth_d = depth_q + CW'(1);
    end
  end

  // Stored heights, addressed by bar index
  hmr_ram #(.WIDTH(HW), .DEPTH(MAX_BARS)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_bar && !count_full),
    .waddr_i (IW'(count_q)),
    .wdata_i (bar_height_i[HW-1:0]),
    .raddr_i (idx_d),
    .rdata_o (h_rd)
  );

  // Left bound plus one per bar (zero when no lower bar on the left)
  assign left_wr = (depth_q == '0) ? '0 : CW'(top_idx_q) + CW'(1);

  hmr_ram #(.WIDTH(CW), .DEPTH(MAX_BARS)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_left),
    .waddr_i (idx_q),
    .wdata_i (left_wr),
    .raddr_i (idx_d),
    .rdata_o (left_rd)
  );

  // Stack entries below the top; the top itself lives in registers.
  // Read address tracks the entry just under the next top.
  hmr_ram #(.WIDTH(SW), .DEPTH(MAX_BARS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (IW'(depth_q - CW'(1))),
    .wdata_i ({top_h_q, top_idx_q}),
    .raddr_i (IW'(depth_d - CW'(2))),
    .rdata_o (stack_rd)
  );

  // Width between boundaries and area of the current bar
  assign right_bound = (depth_q == '0) ? count_q : CW'(top_idx_q);
  assign span        = right_bound - left_rd;
  assign prod_d      = PW'(span) * PW'(h_rd);
  assign area_sat    = (prod_q > PW'(hmr_pkg::AREA_MAX)) ? hmr_pkg::AREA_MAX
                                                        : prod_q[hmr_pkg::AREA_W-1:0];

  // Status
  assign sts_o.pop_ok    = (depth_q != '0) && (h_rd <= top_h_q);
  assign sts_o.at_end_up = (CW'(idx_q) == count_q - CW'(1));
  assign sts_o.at_zero   = (idx_q == '0);
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      depth_q     <= '0;
      best_q      <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      depth_q    <= depth_d;
      prod_vld_q <= cmd_i.push_right;
      if (cmd_i.emit) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load_bar) begin
        if (count_full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.start_right) begin
        best_q <= '0;
      end else if (prod_vld_q && (area_sat > best_q)) begin
        best_q <= area_sat;
      end
      if (cmd_i.emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.pop) begin
      {top_h_q, top_idx_q} <= stack_rd;
    end else if (push) begin
      top_h_q   <= h_rd;
      top_idx_q <= idx_q;
    end
    if (cmd_i.push_right) begin
      prod_q <= prod_d;
    end
    if (cmd_i.emit) begin
      max_area_o   <= best_q;
      overflowed_o <= ovf_q;
    end
  end

endmodule

// File: rtl/histogram_max_rectangle.sv
// Bars are taken one per cycle while the controller is idle (ready is low otherwise).
// After the last bar, a left-boundary stack pass and a right stack pass that
// computes areas run over the bars, then the best area goes to the result register.
// One histogram is evaluated at a time; the result register frees the input.
// Reset (async, active low) empties the histogram; memories are not cleared.
module histogram_max_rectangle #(
  parameter int MAX_BARS    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hmr_bar_if.sink           bar_i,
  hmr_area_if.source        area_o
);

  hmr_pkg::cmd_t cmd;
  hmr_pkg::sts_t sts;

  hmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bar_i.valid),
    .in_last_i  (bar_i.last_bar),
    .sts_i      (sts),
    .in_ready_o (bar_i.ready),
    .cmd_o      (cmd)
  );

  hmr_dp #(
    .MAX_BARS    (MAX_BARS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .bar_height_i (bar_i.bar_height),
    .out_ready_i  (area_o.ready),
    .out_valid_o  (area_o.valid),
    .max_area_o   (area_o.max_area),
    .overflowed_o (area_o.overflowed)
  );

endmodule
